[hdl/bspe_pkg.sv]
// bspe_pkg: shared types and constants for the BMP stream pixel extractor.
// No dependencies; used by every module of the block.
`default_nettype none

package bspe_pkg;

	// File layout constants
	localparam logic [7:0]  SIG_B       = 8'h42;	// 'B'
	localparam logic [7:0]  SIG_M       = 8'h4D;	// 'M'
	localparam logic [31:0] INFO_40     = 32'd40;
	localparam logic [31:0] INFO_12     = 32'd12;
	localparam logic [31:0] INFO_V4     = 32'd64;
	localparam logic [31:0] INFO_V5A    = 32'd108;
	localparam logic [31:0] INFO_V5B    = 32'd124;
	localparam logic [31:0] BPP_24      = 32'd24;
	localparam logic [31:0] HDR_END_40  = 32'd54;	// 14-byte file header + 40
	localparam logic [31:0] HDR_END_12  = 32'd26;	// 14-byte file header + 12

	localparam int IMG_W  = 13;	// width of image_width / image_height ports
	localparam int QDEPTH = 4;	// front-to-back queue depth

	typedef enum logic [1:0] {
		OP_DATA = 2'd0,
		OP_HDR  = 2'd1,
		OP_ERR  = 2'd2
	} bspe_op_t;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_SIG  = 3'd1,
		ST_BPP  = 3'd2,
		ST_COMP = 3'd3,
		ST_VER  = 3'd4,
		ST_UNK  = 3'd5,
		ST_SIZE = 3'd6
	} bspe_status_t;

	typedef enum logic [1:0] {
		KIND_PIX = 2'd0,
		KIND_HDR = 2'd1,
		KIND_ERR = 2'd2
	} bspe_kind_t;

	// Control part of one queue entry
	typedef struct packed {
		bspe_op_t     op;
		bspe_status_t status;
	} bspe_ent_t;

endpackage

`default_nettype wire

[hdl/bmp_stream_pixel_extractor_top.sv]
// bmp_stream_pixel_extractor_top: 24-bit BMP byte stream to RGB pixel stream.
// Instantiates bspe_front, bspe_queue and bspe_back; depends on bspe_pkg.
`default_nettype none

// Feed a BMP file one byte per beat, start_of_file set on its first byte.
// The block checks the "BM" signature, parses the file header and a 40-byte
// or 12-byte info header, and answers with one header beat (kind 1, with
// image_width/image_height) or one error beat (kind 2, with status). After a
// good header it skips to the pixel data offset, drops row padding, and sends
// one pixel beat (kind 0) for every B, G, R byte triple; the final pixel has
// last_pixel set. After an error or the last pixel, bytes are ignored until
// the next start_of_file. Fields that do not belong to a beat's kind read 0.
// Throughput is one byte per clock while the queue is not full: the front end
// decodes each byte combinationally, and the back end turns one queued beat
// into at most one result per cycle when out_stall is low. Results come from
// the queue through a result register. A four-entry queue separates the two
// halves, so the input stalls only when the queue fills under an output stall.
// Dimensions outside 1..MAX_DIM are reported as status 6.
module bmp_stream_pixel_extractor_top #(
	parameter int MAX_DIM = 4096
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   data_byte,
	input  wire logic         start_of_file,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [1:0]        kind,
	output logic [2:0]        status,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic [12:0]       image_width,
	output logic [12:0]       image_height,
	output logic              last_pixel
);
	import bspe_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	// queue beat: control, byte, width, height
	localparam int EW = $bits(bspe_ent_t) + 8 + 2 * DIM_W;

	// front side
	logic              f_push;
	bspe_ent_t         f_ent;
	logic [7:0]        f_byte;
	logic [DIM_W-1:0]  f_w, f_h;

	// queue head
	logic [EW-1:0]     q_din, q_dout;
	logic              q_full, q_nonempty, q_pop;
	bspe_ent_t         q_ent;
	logic [7:0]        q_byte;
	logic [DIM_W-1:0]  q_w, q_h;

	// input stalls only on a full queue
	assign in_stall = q_full;

	bspe_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.push          (f_push),
		.ent           (f_ent),
		.ent_byte      (f_byte),
		.ent_width     (f_w),
		.ent_height    (f_h)
	);

	assign q_din = {f_ent, f_byte, f_w, f_h};

	// front only pushes on a taken byte, and a byte is only taken when not full
	bspe_queue #(.W(EW), .DEPTH(QDEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push && in_valid && !in_stall),
		.din      (q_din),
		.full     (q_full),
		.pop      (q_pop),
		.dout     (q_dout),
		.nonempty (q_nonempty)
	);

	assign {q_ent, q_byte, q_w, q_h} = q_dout;

	bspe_back #(.MAX_DIM(MAX_DIM)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_pop        (q_pop),
		.ent          (q_ent),
		.ent_byte     (q_byte),
		.ent_width    (q_w),
		.ent_height   (q_h),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.status       (status),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.image_width  (image_width),
		.image_height (image_height),
		.last_pixel   (last_pixel)
	);

endmodule

`default_nettype wire

[hdl/bspe_front.sv]
// bspe_front: byte-level header parser and data-offset skipper.
// Classifies each accepted byte and pushes header, error and pixel-byte beats.
// Depends on bspe_pkg.
`default_nettype none

module bspe_front #(
	parameter int MAX_DIM = 4096,
	localparam int DIM_W = $clog2(MAX_DIM + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic [7:0]        data_byte,
	input  wire logic              start_of_file,
	output logic                   push,
	output bspe_pkg::bspe_ent_t    ent,
	output logic [7:0]             ent_byte,
	output logic [DIM_W-1:0]       ent_width,
	output logic [DIM_W-1:0]       ent_height
);
	import bspe_pkg::*;

	typedef enum logic [3:0] {
		PH_HDR  = 4'b0001,
		PH_SKIP = 4'b0010,
		PH_DATA = 4'b0100,
		PH_IDLE = 4'b1000
	} phase_t;

	function automatic logic [DIM_W-1:0] dim_check(input logic [31:0] raw);
		return (raw != '0 && raw <= 32'(MAX_DIM)) ? raw[DIM_W-1:0] : '0;
	endfunction

	phase_t            phase_q, phase_d, ph;
	logic [31:0]       pos_q, pos_d, p;
	logic [31:0]       field_q, field_d;
	logic [31:0]       offset_q, offset_d;
	logic              hdr40_q, hdr40_d;
	logic [DIM_W-1:0]  width_q, width_d;
	logic [DIM_W-1:0]  height_q, height_d;
	logic [5:0]        hp;
	logic              gat, odd2, take;
	logic [1:0]        lane;
	logic [31:0]       asm_v;

	assign take = in_valid && !in_stall;

	always_comb begin
		ph = start_of_file ? PH_HDR : phase_q;
		p  = start_of_file ? '0 : pos_q;
		hp = p[5:0];	// header positions never pass 33

		// which multi-byte field this byte lands in, and its byte lane
		gat  = 1'b0;
		odd2 = 1'b0;
		if (hp == 6'd0) begin
			gat = 1'b1;
		end else if (hp >= 6'd10 && hp <= 6'd17) begin
			gat  = 1'b1;
			odd2 = 1'b1;
		end else if (hp >= 6'd18) begin
			if (hdr40_q) begin
				if (hp <= 6'd25 || hp >= 6'd30) begin
					gat  = 1'b1;
					odd2 = 1'b1;
				end else if (hp >= 6'd28) begin
					gat = 1'b1;
				end
			end else begin
				if (hp <= 6'd19) begin
					gat  = 1'b1;
					odd2 = 1'b1;
				end else if (hp <= 6'd21 || hp == 6'd24 || hp == 6'd25) begin
					gat = 1'b1;
				end
			end
		end
		// field bases sit at 2 or 0 mod 4
		lane  = odd2 ? {~hp[1], hp[0]} : hp[1:0];
		asm_v = ((lane == 2'd0) ? '0 : field_q) | (32'(data_byte) << {lane, 3'b000});

		phase_d    = ph;
		pos_d      = p;
		field_d    = gat ? asm_v : field_q;
		offset_d   = offset_q;
		hdr40_d    = hdr40_q;
		width_d    = width_q;
		height_d   = height_q;
		push       = 1'b0;
		ent.op     = OP_DATA;
		ent.status = ST_OK;
		ent_byte   = data_byte;
		ent_width  = width_q;
		ent_height = height_q;

		case (ph)
			PH_HDR: begin
				pos_d = p + 32'd1;
				if (hp == 6'd1) begin
					if (field_q != 32'(SIG_B) || data_byte != SIG_M) begin
						push       = 1'b1;
						ent.op     = OP_ERR;
						ent.status = ST_SIG;
					end
				end else if (hp == 6'd13) begin
					offset_d = asm_v;
				end else if (hp == 6'd17) begin
					hdr40_d = (asm_v == INFO_40);
					if (asm_v != INFO_40 && asm_v != INFO_12) begin
						push   = 1'b1;
						ent.op = OP_ERR;
						if (asm_v == INFO_V4 || asm_v == INFO_V5A || asm_v == INFO_V5B) begin
							ent.status = ST_VER;
						end else begin
							ent.status = ST_UNK;
						end
					end
				end else if (hdr40_q) begin
					if (hp == 6'd21) width_d = dim_check(asm_v);
					if (hp == 6'd25) height_d = dim_check(asm_v);
					if (hp == 6'd29 && asm_v != BPP_24) begin
						push       = 1'b1;
						ent.op     = OP_ERR;
						ent.status = ST_BPP;
					end
					if (hp == 6'd33) begin
						push = 1'b1;
						if (asm_v != '0) begin
							ent.op     = OP_ERR;
							ent.status = ST_COMP;
						end else if (width_q == '0 || height_q == '0 ||
								offset_q < HDR_END_40) begin
							ent.op     = OP_ERR;
							ent.status = ST_SIZE;
						end else begin
							ent.op = OP_HDR;
						end
					end
				end else begin
					if (hp == 6'd19) width_d = dim_check(asm_v);
					if (hp == 6'd21) height_d = dim_check(asm_v);
					if (hp == 6'd25) begin
						push = 1'b1;
						if (asm_v != BPP_24) begin
							ent.op     = OP_ERR;
							ent.status = ST_BPP;
						end else if (width_q == '0 || height_q == '0 ||
								offset_q < HDR_END_12) begin
							ent.op     = OP_ERR;
							ent.status = ST_SIZE;
						end else begin
							ent.op = OP_HDR;
						end
					end
				end
				if (push) begin
					phase_d = (ent.op == OP_HDR) ? PH_SKIP : PH_IDLE;
				end
			end
			PH_SKIP: begin
				if (p != offset_q) begin
					pos_d = p + 32'd1;
				end else begin
					phase_d = PH_DATA;
					push    = 1'b1;
				end
			end
			PH_DATA: begin
				push = 1'b1;
			end
			PH_IDLE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			pos_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			field_q  <= field_d;
			offset_q <= offset_d;
			hdr40_q  <= hdr40_d;
			width_q  <= width_d;
			height_q <= height_d;
		end
	end

endmodule

`default_nettype wire

[hdl/bspe_queue.sv]
// bspe_queue: small first-word-fall-through queue between front and back.
// Depends on bspe_pkg for the default depth.
`default_nettype none

module bspe_queue #(
	parameter int W = 8,
	parameter int DEPTH = bspe_pkg::QDEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [W-1:0]  din,
	output logic               full,
	input  wire logic          pop,
	output logic [W-1:0]       dout,
	output logic               nonempty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign dout     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop)) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("queue underflow");
`endif

endmodule

`default_nettype wire

[hdl/bspe_back.sv]
// bspe_back: pixel assembler with row/column tracking and the result register.
// Consumes queue beats from bspe_front. Depends on bspe_pkg.
`default_nettype none

module bspe_back #(
	parameter int MAX_DIM = 4096,
	localparam int DIM_W = $clog2(MAX_DIM + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_nonempty,
	output logic                       q_pop,
	input  wire bspe_pkg::bspe_ent_t   ent,
	input  wire logic [7:0]            ent_byte,
	input  wire logic [DIM_W-1:0]      ent_width,
	input  wire logic [DIM_W-1:0]      ent_height,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 kind,
	output logic [2:0]                 status,
	output logic [7:0]                 red,
	output logic [7:0]                 green,
	output logic [7:0]                 blue,
	output logic [12:0]                image_width,
	output logic [12:0]                image_height,
	output logic                       last_pixel
);
	import bspe_pkg::*;

	localparam int COL_W = $clog2(3 * MAX_DIM + 4);

	logic              load_ok;
	logic              active_q, active_d;
	logic [DIM_W-1:0]  height_q, height_d;
	logic [COL_W-1:0]  pix_q, pix_d, rowb_q, rowb_d, pix3;
	logic [COL_W-1:0]  col_q, col_d, col_nxt;
	logic [DIM_W-1:0]  row_q, row_d;
	logic [1:0]        ch_q, ch_d;
	logic [15:0]       held_q, held_d;

	logic              res, r_last;
	bspe_kind_t        r_kind;
	bspe_status_t      r_status;
	logic [7:0]        r_red, r_green, r_blue;
	logic [IMG_W-1:0]  r_w, r_h;

	logic              out_valid_q, last_q;
	bspe_kind_t        kind_q;
	bspe_status_t      status_q;
	logic [7:0]        red_q, green_q, blue_q;
	logic [IMG_W-1:0]  iw_q, ih_q;

	assign load_ok = !out_valid_q || !out_stall;
	assign q_pop   = q_nonempty && load_ok;

	// width * 3 + 3, taken straight from the incoming beat
	assign pix3    = COL_W'({ent_width, 1'b0}) + COL_W'(ent_width) + COL_W'(3);
	assign col_nxt = col_q + COL_W'(1);

	always_comb begin
		active_d = active_q;
		height_d = height_q;
		pix_d    = COL_W'({ent_width, 1'b0}) + COL_W'(ent_width);	// width * 3
		rowb_d   = rowb_q;
		col_d    = col_q;
		row_d    = row_q;
		ch_d     = ch_q;
		held_d   = held_q;
		res      = 1'b0;
		r_last   = 1'b0;
		r_kind   = KIND_PIX;
		r_status = ST_OK;
		r_red    = '0;
		r_green  = '0;
		r_blue   = '0;
		r_w      = '0;
		r_h      = '0;

		case (ent.op)
			OP_HDR: begin
				res      = 1'b1;
				r_kind   = KIND_HDR;
				r_w      = IMG_W'(ent_width);
				r_h      = IMG_W'(ent_height);
				active_d = 1'b1;
				height_d = ent_height;
				rowb_d   = {pix3[COL_W-1:2], 2'b00};	// rounded up to 4 bytes
				col_d    = '0;
				row_d    = '0;
				ch_d     = '0;
				held_d   = '0;
			end
			OP_ERR: begin
				res      = 1'b1;
				r_kind   = KIND_ERR;
				r_status = ent.status;
				active_d = 1'b0;
			end
			OP_DATA: begin
				pix_d = pix_q;
				if (active_q) begin
					if (col_q < pix_q) begin
						case (ch_q)
							2'd0: begin
								held_d = {8'd0, ent_byte};
								ch_d   = 2'd1;
							end
							2'd1: begin
								held_d = {ent_byte, held_q[7:0]};
								ch_d   = 2'd2;
							end
							default: begin
								res     = 1'b1;
								r_red   = ent_byte;
								r_green = held_q[15:8];
								r_blue  = held_q[7:0];
								ch_d    = 2'd0;
								if (row_q == height_q - DIM_W'(1) &&
										col_q == pix_q - COL_W'(1)) begin
									r_last   = 1'b1;
									active_d = 1'b0;
								end
							end
						endcase
					end
					if (col_nxt >= rowb_q) begin
						col_d = '0;
						ch_d  = 2'd0;
						row_d = row_q + DIM_W'(1);
					end else begin
						col_d = col_nxt;
					end
				end
			end
			default: begin
				pix_d = pix_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			ch_q        <= '0;
		end else begin
			if (q_pop) begin
				active_q <= active_d;
				col_q    <= col_d;
				row_q    <= row_d;
				ch_q     <= ch_d;
			end
			if (load_ok) out_valid_q <= q_pop && res;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			height_q <= height_d;
			pix_q    <= pix_d;
			rowb_q   <= rowb_d;
			held_q   <= held_d;
		end
		if (q_pop && res) begin
			kind_q   <= r_kind;
			status_q <= r_status;
			red_q    <= r_red;
			green_q  <= r_green;
			blue_q   <= r_blue;
			iw_q     <= r_w;
			ih_q     <= r_h;
			last_q   <= r_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign status       = status_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign image_width  = iw_q;
	assign image_height = ih_q;
	assign last_pixel   = last_q;

`ifndef NO_ASSERTIONS
	a_last_is_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (kind_q == KIND_PIX))
		else $error("last_pixel on a non-pixel result");
	a_hdr_dims: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_HDR) |-> (iw_q != '0 && ih_q != '0))
		else $error("header accepted with zero dimension");
	a_stop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && res && r_last) |=> !active_q)
		else $error("pixel walk still active after last pixel");
`endif

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// testbench: self-checking bench for bmp_stream_pixel_extractor_top.
// Feeds directed and random BMP byte streams and checks every result beat
// against a built-in decoder model; depends on bspe_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
	import bspe_pkg::*;

	localparam int MAX_DIM      = 4096;
	localparam int STALL_LIMIT  = 2000;	// cycles with no beat on either side
	localparam int DRAIN_CYCLES = 20;	// result register plus the 4-deep queue
	localparam int RANDOM_BEATS = 150;	// directed table already sends ~1650
	localparam logic [15:0] SIG_BM = {SIG_B, SIG_M};

	// One result beat as the block presents it
	typedef struct packed {
		bspe_kind_t   kind;
		bspe_status_t status;
		logic [7:0]   red;
		logic [7:0]   green;
		logic [7:0]   blue;
		logic [12:0]  w;
		logic [12:0]  h;
		logic         last;
	} bmp_beat_t;

	// Recipe for one file. cut = header bytes sent, gap = filler before the
	// pixel data, dlen = pixel-area bytes (-1: whole image plus a few extra).
	// typed rows carry the header/error beat written out by hand.
	typedef struct {
		logic         sof;
		logic [15:0]  sig;
		logic [31:0]  hsize;
		logic [31:0]  offset;
		logic [31:0]  width;
		logic [31:0]  height;
		logic [31:0]  bpp;
		logic [31:0]  comp;
		int           cut;
		int           gap;
		int           dlen;
		logic         typed;
		bspe_status_t estat;
	} bmp_file_t;

	typedef enum logic [1:0] {DEC_HDR, DEC_SKIP, DEC_DATA, DEC_DONE} dec_phase_t;

	// DUT ports
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        start_of_file;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [2:0]  status;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [12:0] image_width;
	logic [12:0] image_height;
	logic        last_pixel;

	bmp_stream_pixel_extractor_top #(.MAX_DIM(MAX_DIM)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.start_of_file(start_of_file),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.status       (status),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.image_width  (image_width),
		.image_height (image_height),
		.last_pixel   (last_pixel)
	);

	// Decoder model state
	dec_phase_t  dec_phase;
	logic [31:0] dec_pos;
	logic [31:0] dec_acc;
	logic [31:0] dec_offset;
	logic [31:0] dec_hsize;
	logic [31:0] dec_width;
	logic [31:0] dec_height;
	logic [31:0] dec_col;
	logic [31:0] dec_row;
	logic [15:0] dec_held;
	logic [1:0]  dec_chan;

	bmp_beat_t   results_due[$];	// beats the block still owes, oldest first
	bmp_file_t   file_table[$];	// directed files
	bmp_beat_t   got_beat;
	bmp_beat_t   want_beat;
	int          mismatches = 0;
	int          beats_sent = 0;
	int          quiet_cycles = 0;
	int          src_idle_pct = 27;
	int          sink_idle_pct = 84;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_error(input string msg);
		if (mismatches < 100)
			$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// ---------------------------------------------------------------
	// Decoder model: one byte in, at most one beat out
	// ---------------------------------------------------------------
	task automatic clear_decoder();
		dec_phase  = DEC_HDR;
		dec_pos    = '0;
		dec_acc    = '0;
		dec_offset = '0;
		dec_hsize  = '0;
		dec_width  = '0;
		dec_height = '0;
		dec_col    = '0;
		dec_row    = '0;
		dec_held   = '0;
		dec_chan   = '0;
	endtask

	// little-endian field assembly, k = byte index within the field
	task automatic gather(input int k, input logic [7:0] b);
		dec_acc = ((k == 0) ? 32'd0 : dec_acc) | ({24'd0, b} << (8 * k));
	endtask

	// out-of-range dimensions are held as zero and rejected at header end
	function automatic logic [31:0] dim_ok(input logic [31:0] raw);
		return (raw >= 1 && raw <= MAX_DIM) ? raw : 32'd0;
	endfunction

	task automatic raise_error(input bspe_status_t code, output bmp_beat_t r);
		r = '0;
		r.kind = KIND_ERR;
		r.status = code;
		dec_phase = DEC_DONE;
	endtask

	// size check first, then data offset against the end of the header
	task automatic accept_header(output bmp_beat_t r);
		if (dec_width == 0 || dec_height == 0 || dec_offset < 14 + dec_hsize) begin
			raise_error(ST_SIZE, r);
		end else begin
			r = '0;
			r.kind = KIND_HDR;
			r.w = dec_width[12:0];
			r.h = dec_height[12:0];
			dec_phase = DEC_SKIP;
			dec_col = '0;
			dec_row = '0;
			dec_chan = '0;
			dec_held = '0;
		end
	endtask

	task automatic take_pixel_byte(input logic [7:0] b, output logic hit, output bmp_beat_t r);
		logic [31:0] pix;
		logic [31:0] rowb;
		pix = dec_width * 3;
		rowb = ((pix + 3) >> 2) << 2;
		hit = 1'b0;
		r = '0;
		if (dec_col < pix) begin
			case (dec_chan)
				2'd0: begin
					dec_held = {8'd0, b};
					dec_chan = 2'd1;
				end
				2'd1: begin
					dec_held = {b, dec_held[7:0]};
					dec_chan = 2'd2;
				end
				default: begin
					// file order is B, G, R
					hit = 1'b1;
					r.kind = KIND_PIX;
					r.red = b;
					r.green = dec_held[15:8];
					r.blue = dec_held[7:0];
					dec_chan = 2'd0;
					if (dec_row + 1 == dec_height && dec_col + 1 == pix) begin
						r.last = 1'b1;
						dec_phase = DEC_DONE;	// padding of the last row is ignored
						return;
					end
				end
			endcase
		end
		dec_col++;
		if (dec_col >= rowb) begin
			dec_col = '0;
			dec_chan = 2'd0;
			dec_row++;
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic sof, output logic hit,
			output bmp_beat_t r);
		logic [31:0] p;
		hit = 1'b0;
		r = '0;
		if (sof)
			clear_decoder();
		case (dec_phase)
			DEC_HDR: begin
				p = dec_pos;
				dec_pos = p + 1;
				if (p < 2) begin
					// signature judged once both bytes are in
					if (p == 0)
						dec_acc = {24'd0, b};
					else if (dec_acc != {24'd0, SIG_B} || b != SIG_M) begin
						raise_error(ST_SIG, r);
						hit = 1'b1;
					end
				end else if (p >= 10 && p <= 13) begin
					gather(p - 10, b);
					if (p == 13)
						dec_offset = dec_acc;
				end else if (p >= 14 && p <= 17) begin
					gather(p - 14, b);
					if (p == 17) begin
						dec_hsize = dec_acc;
						if (dec_hsize inside {INFO_V4, INFO_V5A, INFO_V5B}) begin
							raise_error(ST_VER, r);
							hit = 1'b1;
						end else if (dec_hsize != INFO_40 && dec_hsize != INFO_12) begin
							raise_error(ST_UNK, r);
							hit = 1'b1;
						end
					end
				end else if (p >= 18 && dec_hsize == INFO_40) begin
					if (p <= 21) begin
						gather(p - 18, b);
						if (p == 21)
							dec_width = dim_ok(dec_acc);
					end else if (p <= 25) begin
						gather(p - 22, b);
						if (p == 25)
							dec_height = dim_ok(dec_acc);
					end else if (p == 28 || p == 29) begin
						gather(p - 28, b);
						if (p == 29 && dec_acc != BPP_24) begin
							raise_error(ST_BPP, r);
							hit = 1'b1;
						end
					end else if (p >= 30 && p <= 33) begin
						gather(p - 30, b);
						if (p == 33) begin
							if (dec_acc != 0)
								raise_error(ST_COMP, r);
							else
								accept_header(r);
							hit = 1'b1;
						end
					end
				end else if (p >= 18) begin
					// 12-byte core header: 16-bit fields
					if (p <= 19) begin
						gather(p - 18, b);
						if (p == 19)
							dec_width = dim_ok(dec_acc);
					end else if (p <= 21) begin
						gather(p - 20, b);
						if (p == 21)
							dec_height = dim_ok(dec_acc);
					end else if (p == 24 || p == 25) begin
						gather(p - 24, b);
						if (p == 25) begin
							if (dec_acc != BPP_24)
								raise_error(ST_BPP, r);
							else
								accept_header(r);
							hit = 1'b1;
						end
					end
				end
			end
			DEC_SKIP: begin
				if (dec_pos != dec_offset) begin
					dec_pos++;
				end else begin
					dec_phase = DEC_DATA;
					take_pixel_byte(b, hit, r);
				end
			end
			DEC_DATA: take_pixel_byte(b, hit, r);
			default: ;	// error or image done: wait for start_of_file
		endcase
	endtask

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	function automatic logic [7:0] hdr_byte(input bmp_file_t f, input int i);
		logic [7:0] v;
		v = 8'($urandom_range(255));	// reserved and unused header bytes are noise
		if (i == 0)
			v = f.sig[15:8];
		else if (i == 1)
			v = f.sig[7:0];
		else if (i >= 10 && i <= 13)
			v = f.offset[8 * (i - 10) +: 8];
		else if (i >= 14 && i <= 17)
			v = f.hsize[8 * (i - 14) +: 8];
		else if (i >= 18 && f.hsize == INFO_12) begin
			if (i <= 19)
				v = f.width[8 * (i - 18) +: 8];
			else if (i <= 21)
				v = f.height[8 * (i - 20) +: 8];
			else if (i == 24 || i == 25)
				v = f.bpp[8 * (i - 24) +: 8];
		end else if (i >= 18) begin
			if (i <= 21)
				v = f.width[8 * (i - 18) +: 8];
			else if (i <= 25)
				v = f.height[8 * (i - 22) +: 8];
			else if (i == 28 || i == 29)
				v = f.bpp[8 * (i - 28) +: 8];
			else if (i >= 30 && i <= 33)
				v = f.comp[8 * (i - 30) +: 8];
		end
		return v;
	endfunction

	task automatic add_row(input logic sof, input logic [15:0] sig, input logic [31:0] hsize,
			input logic [31:0] offset, input logic [31:0] width, input logic [31:0] height,
			input logic [31:0] bpp, input logic [31:0] comp, input int gap, input int dlen,
			input logic typed, input bspe_status_t estat);
		bmp_file_t f;
		f.sof = sof;
		f.sig = sig;
		f.hsize = hsize;
		f.offset = offset;
		f.width = width;
		f.height = height;
		f.bpp = bpp;
		f.comp = comp;
		f.cut = (hsize == INFO_12) ? int'(HDR_END_12) : int'(HDR_END_40);
		f.gap = gap;
		f.dlen = dlen;
		f.typed = typed;
		f.estat = estat;
		file_table.push_back(f);
	endtask

	// Present one byte beat, hold it through stall, model it once taken.
	task automatic send_beat(input logic [7:0] b, input logic sof, input logic typed,
			input bmp_beat_t typed_res);
		logic hit;
		bmp_beat_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		start_of_file <= sof;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		decode_byte(b, sof, hit, r);
		if (hit)
			results_due.push_back((typed && r.kind != KIND_PIX) ? typed_res : r);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_file(input bmp_file_t f);
		int i;
		int n;
		int wv;
		int rowb;
		bmp_beat_t tr;
		tr = '0;
		tr.kind = (f.estat == ST_OK) ? KIND_HDR : KIND_ERR;
		tr.status = f.estat;
		if (f.estat == ST_OK) begin
			tr.w = f.width[12:0];
			tr.h = f.height[12:0];
		end
		for (i = 0; i < f.cut; i++)
			send_beat(hdr_byte(f, i), f.sof && i == 0, f.typed, tr);
		repeat (f.gap)
			send_beat(8'($urandom_range(255)), 1'b0, f.typed, tr);
		n = f.dlen;
		if (n < 0) begin
			wv = (f.hsize == INFO_12) ? int'(f.width[15:0]) : int'(f.width);
			rowb = ((wv * 3 + 3) / 4) * 4;
			n = rowb * int'(f.height) + $urandom_range(0, 3);
		end
		repeat (n)
			send_beat(8'($urandom_range(255)), 1'b0, f.typed, tr);
	endtask

	// Mostly well-formed small images; the rest cut short, or broken headers and noise.
	function automatic bmp_file_t random_file();
		bmp_file_t f;
		int hend;
		int pick;
		logic [31:0] bad;
		f.sof = ($urandom_range(99) >= 3);
		f.sig = SIG_BM;
		f.hsize = ($urandom_range(3) == 0) ? INFO_12 : INFO_40;
		hend = (f.hsize == INFO_12) ? int'(HDR_END_12) : int'(HDR_END_40);
		f.width = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
		f.height = $urandom_range(1, 4);
		f.bpp = BPP_24;
		f.comp = '0;
		f.gap = $urandom_range(0, 6);
		f.offset = hend + f.gap;
		f.cut = hend;
		f.dlen = -1;
		f.typed = 1'b0;
		f.estat = ST_OK;
		pick = $urandom_range(99);
		if (pick < 8) begin
			f.dlen = $urandom_range(0, 30);	// restart in the middle of the image
		end else if (pick < 12) begin
			f.cut = $urandom_range(2, hend - 1);	// restart in the middle of the header
			f.gap = 0;
			f.dlen = 0;
		end else if (pick >= 70) begin
			f.gap = 0;
			f.dlen = $urandom_range(0, 8);
			case ($urandom_range(7))
				0: f.sig = f.sig ^ (16'h1 << $urandom_range(15));
				1: begin
					case ($urandom_range(2))
						0: f.hsize = INFO_V4;
						1: f.hsize = INFO_V5A;
						default: f.hsize = INFO_V5B;
					endcase
				end
				2: f.hsize = $urandom;
				3: f.bpp = $urandom_range(0, 65535);
				4: f.comp = $urandom | 32'h1 << $urandom_range(31);
				5: begin
					case ($urandom_range(2))
						0: bad = '0;
						1: bad = MAX_DIM + 1 + $urandom_range(0, 60000);
						default: bad = 32'h8000_0000 | $urandom;
					endcase
					if ($urandom_range(1))
						f.width = bad;
					else
						f.height = bad;
				end
				6: f.offset = $urandom_range(0, hend - 1);
				default: begin
					f.sig = 16'($urandom);
					f.hsize = $urandom_range(0, 130);
					f.offset = $urandom;
					f.width = $urandom;
					f.height = $urandom;
					f.bpp = $urandom;
					f.comp = $urandom;
				end
			endcase
		end
		return f;
	endfunction

	// ---------------------------------------------------------------
	// Receiver: random stall, decided at the falling edge
	// ---------------------------------------------------------------
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < sink_idle_pct);

	// ---------------------------------------------------------------
	// Result checking and watchdog, sampled at the rising edge
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					report_error($sformatf("result beat kind %0d with nothing expected", kind));
				end else begin
					want_beat = results_due.pop_front();
					cmp_field("kind", 32'(kind), 32'(want_beat.kind));
					cmp_field("status", 32'(status), 32'(want_beat.status));
					cmp_field("red", 32'(red), 32'(want_beat.red));
					cmp_field("green", 32'(green), 32'(want_beat.green));
					cmp_field("blue", 32'(blue), 32'(want_beat.blue));
					cmp_field("image_width", 32'(image_width), 32'(want_beat.w));
					cmp_field("image_height", 32'(image_height), 32'(want_beat.h));
					cmp_field("last_pixel", 32'(last_pixel), 32'(want_beat.last));
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("testbench: errors");
					$finish;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		int ph;
		int target;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		start_of_file = 1'b0;
		clear_decoder();

		// Directed files. Typed rows pin the header/error beat by hand;
		// pixel beats always come from the model.
		//      sof sig           hsize        offset          width       height
		//      bpp           comp          gap dlen typed status
		// first file right after reset, without start_of_file
		add_row(0, SIG_BM, INFO_40, HDR_END_40, 2, 2, BPP_24, 0, 0, -1, 1, ST_OK);
		// signature: bad first byte, bad second byte
		add_row(1, {8'h41, SIG_M}, INFO_40, HDR_END_40, 2, 2, BPP_24, 0, 0, 4, 1, ST_SIG);
		add_row(1, {SIG_B, 8'h4E}, INFO_40, HDR_END_40, 2, 2, BPP_24, 0, 0, 4, 1, ST_SIG);
		// header sizes: later versions, then unknown ones
		add_row(1, SIG_BM, INFO_V4, HDR_END_40, 2, 2, BPP_24, 0, 0, 2, 1, ST_VER);
		add_row(1, SIG_BM, INFO_V5A, HDR_END_40, 2, 2, BPP_24, 0, 0, 2, 1, ST_VER);
		add_row(1, SIG_BM, INFO_V5B, HDR_END_40, 2, 2, BPP_24, 0, 0, 2, 1, ST_VER);
		add_row(1, SIG_BM, 41, HDR_END_40, 2, 2, BPP_24, 0, 0, 2, 1, ST_UNK);
		add_row(1, SIG_BM, 0, HDR_END_40, 2, 2, BPP_24, 0, 0, 2, 1, ST_UNK);
		add_row(1, SIG_BM, 32'hFFFF_FFFF, HDR_END_40, 2, 2, BPP_24, 0, 0, 2, 1, ST_UNK);
		// pixel format and compression
		add_row(1, SIG_BM, INFO_40, HDR_END_40, 2, 2, 32, 0, 0, 2, 1, ST_BPP);
		add_row(1, SIG_BM, INFO_40, HDR_END_40, 2, 2, 32'hFFFF, 0, 0, 2, 1, ST_BPP);
		add_row(1, SIG_BM, INFO_40, HDR_END_40, 2, 2, BPP_24, 32'hFFFF_FFFF, 0, 2, 1, ST_COMP);
		// dimensions: zero, negative, above the limit; bpp/compression win
		add_row(1, SIG_BM, INFO_40, HDR_END_40, 0, 2, BPP_24, 0, 0, 2, 1, ST_SIZE);
		add_row(1, SIG_BM, INFO_40, HDR_END_40, 32'h8000_0000, 2, BPP_24, 0, 0, 2, 1, ST_SIZE);
		add_row(1, SIG_BM, INFO_40, HDR_END_40, 2, 32'hFFFF_FFFF, BPP_24, 0, 0, 2, 1, ST_SIZE);
		add_row(1, SIG_BM, INFO_40, HDR_END_40, MAX_DIM + 1, 2, BPP_24, 0, 0, 2, 1, ST_SIZE);
		add_row(1, SIG_BM, INFO_40, HDR_END_40, 0, 2, 8, 0, 0, 2, 1, ST_BPP);
		add_row(1, SIG_BM, INFO_40, HDR_END_40, 0, 2, BPP_24, 2, 0, 2, 1, ST_COMP);
		// data offset one byte inside the header
		add_row(1, SIG_BM, INFO_40, HDR_END_40 - 1, 2, 2, BPP_24, 0, 0, 2, 1, ST_SIZE);
		// largest accepted sizes; pixel data cut short by the next file
		add_row(1, SIG_BM, INFO_40, HDR_END_40, MAX_DIM, 1, BPP_24, 0, 0, 30, 1, ST_OK);
		add_row(1, SIG_BM, INFO_40, HDR_END_40, 1, MAX_DIM, BPP_24, 0, 0, 24, 1, ST_OK);
		add_row(1, SIG_BM, INFO_40, HDR_END_40, MAX_DIM, MAX_DIM, BPP_24, 0, 0, 12, 1, ST_OK);
		// 12-byte core header
		add_row(1, SIG_BM, INFO_12, HDR_END_12, 3, 2, BPP_24, 0, 0, -1, 1, ST_OK);
		add_row(1, SIG_BM, INFO_12, HDR_END_12, 16'hFFFF, 2, BPP_24, 0, 0, 2, 1, ST_SIZE);
		add_row(1, SIG_BM, INFO_12, HDR_END_12, 3, 2, 8, 0, 0, 2, 1, ST_BPP);
		add_row(1, SIG_BM, INFO_12, HDR_END_12 - 1, 3, 2, BPP_24, 0, 0, 2, 1, ST_SIZE);
		// skip gap, row padding and trailing bytes after the last pixel
		add_row(1, SIG_BM, INFO_40, HDR_END_40 + 6, 5, 3, BPP_24, 0, 6, -1, 0, ST_OK);
		add_row(1, SIG_BM, INFO_12, HDR_END_12 + 3, 1, 3, BPP_24, 0, 3, -1, 0, ST_OK);
		// data offset far past the stream: header beat, then skipping only
		add_row(1, SIG_BM, INFO_40, 32'hFFFF_FF00, 2, 2, BPP_24, 0, 10, 0, 1, ST_OK);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (file_table[i])
			send_file(file_table[i]);

		// Random files in three pressure phases: busy sender with a stalling
		// receiver, the reverse, then full rate on both sides.
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 27;
					sink_idle_pct = 84;
				end
				1: begin
					src_idle_pct = 84;
					sink_idle_pct = 27;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
			endcase
			target = beats_sent + RANDOM_BEATS / 3;
			while (beats_sent < target)
				send_file(random_file());
		end

		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

[filelist.f]
hdl/bspe_pkg.sv
hdl/bspe_front.sv
hdl/bspe_queue.sv
hdl/bspe_back.sv
hdl/bmp_stream_pixel_extractor_top.sv
tb/sv/testbench.sv
